>>> rtl/event_lif_neuron_macros.svh
// ----------------------------------------------------------------------------
// event_lif_neuron_macros.svh
// Assertion macros used by the neuron checker. They use the clk and rst_n
// signals of the scope in which they stand.
// ----------------------------------------------------------------------------
`ifndef EVENT_LIF_NEURON_MACROS_SVH
`define EVENT_LIF_NEURON_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define ELIF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted
`define ELIF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Behaviour in the cycle after a reset edge
`define ELIF_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) else $error(msg);

`endif

>>> rtl/elif_pkg.sv
// ----------------------------------------------------------------------------
// elif_pkg
// Types, codes and constants of the event-driven LIF neuron.
// ----------------------------------------------------------------------------
package elif_pkg;

  localparam int FIELD_WIDTH_DEF  = 16;
  localparam int FIELD_HEIGHT_DEF = 16;

  // Command codes
  localparam logic [1:0] CMD_EVENT = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_PROBE = 2'd2;

  // Register indexes
  localparam logic [0:0] REG_THRESHOLD  = 1'b0;
  localparam logic [0:0] REG_DECAY_RATE = 1'b1;

  localparam logic signed [31:0] THRESHOLD_RST  = 32'sd655360;
  localparam logic        [31:0] DECAY_RATE_RST = 32'd0;
  localparam logic signed [15:0] WEIGHT_ONE     = 16'sd256;

  typedef enum logic {ST_CLEAR, ST_RUN} elif_state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        timestamp;
    logic [3:0]         pixel_x;
    logic [3:0]         pixel_y;
    logic               polarity;
    logic signed [15:0] weight_value;
  } elif_in_t;

  typedef struct packed {
    logic               spike;
    logic signed [31:0] potential;
  } elif_out_t;

  // After the accept stage
  typedef struct packed {
    logic [1:0]  cmd;
    logic        in_field;
    logic [31:0] dt;
  } elif_s1_t;

  // After the decay multiplier
  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] weight;
    logic [31:0]        loss;
  } elif_s2_t;

endpackage

>>> rtl/elif_weight_ram.sv
// ----------------------------------------------------------------------------
// elif_weight_ram
// Single-port weight memory, ON and OFF tables interleaved, registered read.
// ----------------------------------------------------------------------------
module elif_weight_ram
  import elif_pkg::*;
#(
  parameter int DEPTH = 2 * FIELD_WIDTH_DEF * FIELD_HEIGHT_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic signed [15:0]       wdata,
  output logic signed [15:0]       rdata
);

  logic signed [15:0] mem [DEPTH];
  logic signed [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/elif_decay_mul.sv
// ----------------------------------------------------------------------------
// elif_decay_mul
// Leak stage: elapsed time times decay rate, clamped to 2^31.
// ----------------------------------------------------------------------------
module elif_decay_mul
  import elif_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  elif_s1_t           s1,
  input  logic signed [15:0] weight,
  input  logic [31:0]        decay_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output elif_s2_t           s2
);

  logic [63:0] product;
  logic [31:0] loss_clamped;
  logic        s2_v_r;
  elif_s2_t    s2_r;

  // Any loss of 2^31 or more wipes out every positive potential
  assign product      = 64'(s1.dt) * 64'(decay_rate);
  assign loss_clamped = (|product[63:31]) ? 32'h8000_0000 : product[31:0];

  assign in_ready = !s2_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (in_ready) begin
      s2_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s2_r.cmd    <= s1.cmd;
      s2_r.weight <= s1.in_field ? weight : 16'sd0;
      s2_r.loss   <= loss_clamped;
    end
  end

  assign out_valid = s2_v_r;
  assign s2        = s2_r;

endmodule

>>> rtl/elif_soma.sv
// ----------------------------------------------------------------------------
// elif_soma
// Membrane potential register, leak, integrate and fire, result register.
// ----------------------------------------------------------------------------
module elif_soma
  import elif_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  elif_s2_t           s2,
  input  logic signed [31:0] threshold,
  output logic               out_valid,
  input  logic               out_ready,
  output elif_out_t          out_item
);

  logic signed [31:0] pot_r;
  logic signed [31:0] pot_nxt;
  logic               out_v_r;
  elif_out_t          out_r;
  elif_out_t          res_nxt;

  logic        pot_pos;
  logic [31:0] decayed;
  logic signed [33:0] w_q16;
  logic signed [33:0] sum;
  logic signed [31:0] sat;
  logic               fire;

  always_comb begin
    pot_pos = !pot_r[31] && (pot_r != 32'sd0);
    decayed = (pot_pos && (s2.loss < 32'(pot_r))) ? 32'(pot_r) - s2.loss : 32'd0;
    w_q16   = {{10{s2.weight[15]}}, s2.weight, 8'h00};
    sum     = $signed({2'b00, decayed}) + w_q16;
    if ((sum[33:31] == 3'b000) || (sum[33:31] == 3'b111)) begin
      sat = sum[31:0];
    end else if (sum[33]) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = 32'sh7fff_ffff;
    end
    fire = sat > threshold;

    pot_nxt = pot_r;
    res_nxt.spike     = 1'b0;
    res_nxt.potential = pot_r;
    case (s2.cmd)
      CMD_EVENT: begin
        pot_nxt           = fire ? 32'sd0 : sat;
        res_nxt.spike     = fire;
        res_nxt.potential = pot_nxt;
      end
      CMD_PROBE: begin
        res_nxt.potential = $signed(decayed);
      end
      default: begin
      end
    endcase
  end

  assign in_ready = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      pot_r   <= 32'sd0;
    end else if (in_ready) begin
      out_v_r <= in_valid;
      if (in_valid) begin
        pot_r <= pot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

endmodule

>>> rtl/event_lif_neuron.sv
// ----------------------------------------------------------------------------
// event_lif_neuron
// Event-driven leaky integrate-and-fire neuron with linear leak and per-pixel
// ON/OFF weights held in a synchronous memory.
// ----------------------------------------------------------------------------
// Pipeline: the accept stage registers the item and the weight read at the transfer,
//   the leak multiply registers the loss, integrate and fire fills the result register.
// Throughput: one item per cycle while out_ready is high; the potential update closes
//   its loop in the soma stage, and the weight memory sees at most one access per item.
// Reset: a clearing pass loads 1.0 into every weight, one entry per cycle,
//   2*FIELD_WIDTH*FIELD_HEIGHT entries (512 by default); in_ready stays low
//   meanwhile, configuration writes are still taken.
module event_lif_neuron
  import elif_pkg::*;
#(
  parameter int FIELD_WIDTH  = FIELD_WIDTH_DEF,
  parameter int FIELD_HEIGHT = FIELD_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  elif_in_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output elif_out_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NCELLS = FIELD_WIDTH * FIELD_HEIGHT;
  localparam int DEPTH  = 2 * NCELLS;
  localparam int AW     = $clog2(DEPTH);

  // Configuration registers
  logic signed [31:0] threshold_r;
  logic        [31:0] decay_rate_r;

  // Clearing sequencer
  elif_state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          clr_we;

  // Accept stage
  logic          in_fire;
  logic          in_field;
  logic [31:0]   cell_addr_full;
  logic [AW-1:0] cell_addr;
  logic [31:0]   last_time_r;
  logic [31:0]   dt;
  logic          s1_v_r;
  elif_s1_t      s1_r;

  // Memory port
  logic               ram_we;
  logic               ram_re;
  logic [AW-1:0]      ram_addr;
  logic signed [15:0] ram_wdata;
  logic signed [15:0] ram_rdata;

  // Pipeline links
  logic     mul_ready;
  logic     s2_valid;
  logic     soma_ready;
  elif_s2_t s2;

  // ---------------------------------------------------------------------------
  // Configuration: always ready, idle-time writes only by contract
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THRESHOLD_RST;
      decay_rate_r <= DECAY_RATE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD:  threshold_r  <= $signed(cfg_data);
        REG_DECAY_RATE: decay_rate_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing pass after reset: sweep every memory entry to 1.0
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    clr_we      = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        clr_we = 1'b1;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_RUN;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_RUN: begin
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Accept stage: address decode, weight read or write, elapsed time
  // ---------------------------------------------------------------------------
  assign in_ready = (state_r == ST_RUN) && (!s1_v_r || mul_ready);
  assign in_fire  = in_valid && in_ready;

  // ON and OFF entries of a pixel sit side by side: address = 2*cell + polarity
  assign in_field = (int'(in_item.pixel_x) < FIELD_WIDTH) &&
                    (int'(in_item.pixel_y) < FIELD_HEIGHT);
  assign cell_addr_full = 32'((int'(in_item.pixel_y) * FIELD_WIDTH +
                               int'(in_item.pixel_x)) * 2 + int'(in_item.polarity));
  assign cell_addr = cell_addr_full[AW-1:0];

  // A write lands at the transfer edge, so any later read already sees it
  assign ram_we    = clr_we || (in_fire && (in_item.command == CMD_WRITE) && in_field);
  assign ram_re    = in_fire && (in_item.command == CMD_EVENT) && in_field;
  assign ram_addr  = clr_we ? clr_cnt_r : cell_addr;
  assign ram_wdata = clr_we ? WEIGHT_ONE : in_item.weight_value;

  // An older timestamp counts as no time elapsed
  assign dt = (in_item.timestamp >= last_time_r) ? in_item.timestamp - last_time_r
                                                 : 32'd0;

  // Advance the event time at an event's transfer; it feeds the next item's dt directly
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= 32'd0;
    end else if (in_fire && (in_item.command == CMD_EVENT)) begin
      last_time_r <= in_item.timestamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (mul_ready) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.cmd      <= in_item.command;
      s1_r.in_field <= in_field;
      s1_r.dt       <= dt;
    end
  end

  elif_weight_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Leak multiply, then integrate and fire
  // ---------------------------------------------------------------------------
  elif_decay_mul u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s1_v_r),
    .in_ready   (mul_ready),
    .s1         (s1_r),
    .weight     (ram_rdata),
    .decay_rate (decay_rate_r),
    .out_valid  (s2_valid),
    .out_ready  (soma_ready),
    .s2         (s2)
  );

  elif_soma u_soma (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_ready  (soma_ready),
    .s2        (s2),
    .threshold (threshold_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

>>> rtl/event_lif_neuron_chk.sv
// ----------------------------------------------------------------------------
// event_lif_neuron_chk
// Port-level checks of the neuron, bound to the top level.
// ----------------------------------------------------------------------------
`include "event_lif_neuron_macros.svh"

module event_lif_neuron_chk
  import elif_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input elif_in_t    in_item,
  input logic        out_valid,
  input logic        out_ready,
  input elif_out_t   out_item
);

  // A waiting input holds until its transfer
  `ELIF_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_item), "input dropped")

  // A stalled result holds
  `ELIF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "result changed while stalled")

  // Firing returns the potential to zero
  `ELIF_ASSERT_NOW(a_spike_zero, out_valid && out_item.spike, out_item.potential == 32'sd0, "spike with nonzero potential")

  // After reset the weight sweep runs and nothing is in flight
  `ELIF_ASSERT_RST(a_rst_quiet, !in_ready && !out_valid, "input taken or result shown after reset")

endmodule

bind event_lif_neuron event_lif_neuron_chk u_chk (.*);
